// ===== rtl/core/bse_pkg.sv =====
// Shared constants and control types for the byte entropy block.
package bse_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_BINS       = 256;
    localparam int BIN_W          = 8;
    localparam int GUARD_BITS     = 8;
    localparam int MANT_W         = 31;
    localparam int ENT_W          = 20;
    localparam int TOT_W          = 32;
    localparam int S_DATA_W       = 8;
    localparam int M_DATA_W       = 56;

    typedef struct packed {
        logic accept;
        logic log_start;
        logic log_src_bin;
        logic save_ln;
        logic rd_bin;
        logic load_c;
        logic term_start;
        logic idx_inc;
        logic out_load;
        logic blk_clear;
    } cmd_t;

    typedef struct packed {
        logic last_beat;
        logic total_zero;
        logic log_done;
        logic bin_zero;
        logic term_done;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/bse_hist.sv =====
// Histogram memory with per-bin valid bits and a forwarded increment stage.
module bse_hist #(
    parameter int COUNT_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              rd_addr,
    input  logic                    cnt_en,
    input  logic                    clear,
    output logic [COUNT_BITS-1:0]   bin_val
);
    import bse_pkg::*;

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]   bin_vld_reg;
    logic [COUNT_BITS-1:0] rd_q_reg;
    logic                  vq_reg;
    logic                  s1_vld_reg;
    logic [BIN_W-1:0]      s1_addr_reg;
    logic                  wr_vld_reg;
    logic [BIN_W-1:0]      wr_addr_reg;
    logic [COUNT_BITS-1:0] wr_data_reg;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;

    assign bin_val = vq_reg ? rd_q_reg : '0;

    always_comb begin
        cur = (wr_vld_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : bin_val;
        inc = (&cur) ? cur : cur + COUNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        rd_q_reg <= mem[rd_addr];
        if (s1_vld_reg) begin
            mem[s1_addr_reg] <= inc;
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= rd_addr;
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= inc;
        if (!aresetn) begin
            bin_vld_reg <= '0;
            vq_reg      <= 1'b0;
            s1_vld_reg  <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end else begin
            vq_reg     <= bin_vld_reg[rd_addr];
            s1_vld_reg <= cnt_en;
            wr_vld_reg <= s1_vld_reg;
            if (clear) begin
                bin_vld_reg <= '0;
            end else if (s1_vld_reg) begin
                bin_vld_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/bse_log.sv =====
// Iterative fixed-point log2 unit: bit-serial normalize, then repeated squaring.
module bse_log #(
    parameter int COUNT_BITS = 32,
    parameter int LOG_FRAC   = 24,
    parameter int KW         = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] x,
    output logic                  done,
    output logic [KW-1:0]         k_out,
    output logic [LOG_FRAC-1:0]   frac_out
);
    import bse_pkg::*;

    localparam int CW = $clog2(LOG_FRAC);

    logic [COUNT_BITS-1:0]        x_reg;
    logic [KW-1:0]                k_reg;
    logic [MANT_W-1:0]            m_reg;
    logic [LOG_FRAC-1:0]          frac_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         norm_reg;
    logic                         iter_reg;
    logic                         done_reg;
    logic [COUNT_BITS+MANT_W-1:0] ext;
    logic [2*MANT_W-1:0]          sq;
    logic                         fbit;

    assign ext  = {x_reg, {MANT_W{1'b0}}};
    assign sq   = m_reg * m_reg;
    assign fbit = sq[2*MANT_W-1];

    assign done     = done_reg;
    assign k_out    = k_reg;
    assign frac_out = frac_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x;
            k_reg <= KW'(COUNT_BITS - 1);
        end else if (norm_reg && !x_reg[COUNT_BITS-1]) begin
            x_reg <= {x_reg[COUNT_BITS-2:0], 1'b0};
            k_reg <= k_reg - KW'(1);
        end
        if (norm_reg && x_reg[COUNT_BITS-1]) begin
            m_reg    <= ext[COUNT_BITS+MANT_W-1 -: MANT_W];
            frac_reg <= '0;
            cnt_reg  <= '0;
        end else if (iter_reg) begin
            m_reg    <= fbit ? sq[2*MANT_W-1 -: MANT_W] : sq[2*MANT_W-2 -: MANT_W];
            frac_reg <= {frac_reg[LOG_FRAC-2:0], fbit};
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg <= 1'b0;
            iter_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                norm_reg <= 1'b1;
            end else if (norm_reg && x_reg[COUNT_BITS-1]) begin
                norm_reg <= 1'b0;
                iter_reg <= 1'b1;
            end else if (iter_reg && (cnt_reg == CW'(LOG_FRAC - 1))) begin
                iter_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/bse_dp.sv =====
// Datapath: histogram, byte count, log2 unit, serial multiply-divide and result register.
module bse_dp #(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bse_pkg::cmd_t                 cmd,
    output bse_pkg::status_t              status,
    input  logic                          s_tvalid,
    input  logic [bse_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bse_pkg::M_DATA_W-1:0]  m_tdata
);
    import bse_pkg::*;

    localparam int LOG_FRAC = FRAC_BITS + GUARD_BITS;
    localparam int KW       = $clog2(COUNT_BITS);
    localparam int LW       = KW + LOG_FRAC;
    localparam int PW       = COUNT_BITS + LW;
    localparam int SW       = LW + BIN_W;
    localparam int RW       = SW + 1 - GUARD_BITS;
    localparam int TW       = $clog2(PW + 1);
    localparam logic [RW-1:0] ENT_MAX = RW'(8) << FRAC_BITS;

    logic                  beat;
    logic [BIN_W-1:0]      idx_reg;
    logic [BIN_W-1:0]      rd_addr;
    logic [COUNT_BITS-1:0] bin_val;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] c_reg;
    logic [COUNT_BITS-1:0] log_x;
    logic                  log_done;
    logic [KW-1:0]         log_k;
    logic [LOG_FRAC-1:0]   log_frac;
    logic [LW-1:0]         lc;
    logic [LW-1:0]         ln_reg;
    logic [LW-1:0]         b_reg;
    logic [LW-1:0]         q_reg;
    logic [PW-1:0]         prod_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS:0]   trial;
    logic                  ge;
    logic [TW-1:0]         tcnt_reg;
    logic                  mul_reg;
    logic                  div_reg;
    logic                  tdone_reg;
    logic [SW-1:0]         sum_reg;
    logic [SW:0]           rsum;
    logic [RW-1:0]         res;
    logic [ENT_W-1:0]      ent;
    logic [TOT_W-1:0]      tot;
    logic                  mv_reg;
    logic [ENT_W-1:0]      ent_reg;
    logic [TOT_W-1:0]      tot_reg;

    assign beat    = s_tvalid && cmd.accept;
    assign rd_addr = cmd.rd_bin ? idx_reg : s_tdata[BIN_W-1:0];
    assign log_x   = cmd.log_src_bin ? bin_val : total_reg;
    assign lc      = {log_k, log_frac};

    bse_hist #(.COUNT_BITS(COUNT_BITS)) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .cnt_en  (beat && s_tuser),
        .clear   (cmd.blk_clear),
        .bin_val (bin_val)
    );

    bse_log #(.COUNT_BITS(COUNT_BITS), .LOG_FRAC(LOG_FRAC), .KW(KW)) u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.log_start),
        .x        (log_x),
        .done     (log_done),
        .k_out    (log_k),
        .frac_out (log_frac)
    );

    assign trial = {rem_reg, prod_reg[PW-1]};
    assign ge    = trial >= {1'b0, total_reg};

    always_ff @(posedge aclk) begin
        if (cmd.save_ln) begin
            ln_reg <= lc;
        end
        if (cmd.load_c) begin
            c_reg <= bin_val;
        end
        if (cmd.term_start) begin
            prod_reg <= '0;
            b_reg    <= ln_reg - lc;
            rem_reg  <= '0;
            q_reg    <= '0;
        end else if (mul_reg) begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0} + (b_reg[LW-1] ? PW'(c_reg) : '0);
            b_reg    <= {b_reg[LW-2:0], 1'b0};
        end else if (div_reg) begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= ge ? COUNT_BITS'(trial - {1'b0, total_reg}) : trial[COUNT_BITS-1:0];
            q_reg    <= {q_reg[LW-2:0], ge};
        end
        if (cmd.out_load) begin
            ent_reg <= ent;
            tot_reg <= tot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            mul_reg   <= 1'b0;
            div_reg   <= 1'b0;
            tdone_reg <= 1'b0;
            tcnt_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            tdone_reg <= 1'b0;
            if (cmd.blk_clear) begin
                total_reg <= '0;
                sum_reg   <= '0;
                idx_reg   <= '0;
            end else begin
                if (beat && s_tuser && !(&total_reg)) begin
                    total_reg <= total_reg + COUNT_BITS'(1);
                end
                if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + BIN_W'(1);
                end
                if (div_reg && (tcnt_reg == TW'(PW - 1))) begin
                    sum_reg <= sum_reg + SW'({q_reg[LW-2:0], ge});
                end
            end
            if (cmd.term_start) begin
                tcnt_reg <= '0;
                if (lc >= ln_reg) begin
                    tdone_reg <= 1'b1;
                end else begin
                    mul_reg <= 1'b1;
                end
            end else if (mul_reg) begin
                if (tcnt_reg == TW'(LW - 1)) begin
                    mul_reg  <= 1'b0;
                    div_reg  <= 1'b1;
                    tcnt_reg <= '0;
                end else begin
                    tcnt_reg <= tcnt_reg + TW'(1);
                end
            end else if (div_reg) begin
                if (tcnt_reg == TW'(PW - 1)) begin
                    div_reg   <= 1'b0;
                    tdone_reg <= 1'b1;
                end else begin
                    tcnt_reg <= tcnt_reg + TW'(1);
                end
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        rsum = {1'b0, sum_reg} + (SW + 1)'(1 << (GUARD_BITS - 1));
        res  = rsum[SW:GUARD_BITS];
        if (res > ENT_MAX) begin
            res = ENT_MAX;
        end
        ent = res[ENT_W-1:0];
    end

    generate
        if (COUNT_BITS > TOT_W) begin : g_tot_sat
            assign tot = (|total_reg[COUNT_BITS-1:TOT_W]) ? '1 : total_reg[TOT_W-1:0];
        end else begin : g_tot_ext
            assign tot = TOT_W'(total_reg);
        end
    endgenerate

    assign status.last_beat  = beat && s_tlast;
    assign status.total_zero = (total_reg == '0);
    assign status.log_done   = log_done;
    assign status.bin_zero   = (bin_val == '0);
    assign status.term_done  = tdone_reg;
    assign status.idx_last   = &idx_reg;
    assign status.out_free   = !mv_reg || m_tready;

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(M_DATA_W - ENT_W - TOT_W){1'b0}}, tot_reg, ent_reg};

endmodule

// ===== rtl/core/bse_ctrl.sv =====
// Controller state machine that sequences counting, the bin walk and result hand-off.
module bse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  bse_pkg::status_t  status,
    output bse_pkg::cmd_t     cmd
);
    import bse_pkg::*;

    typedef enum logic [8:0] {
        ST_RUN   = 9'b000000001,
        ST_DRAIN = 9'b000000010,
        ST_LOGN  = 9'b000000100,
        ST_RDBIN = 9'b000001000,
        ST_BIN   = 9'b000010000,
        ST_LOGC  = 9'b000100000,
        ST_TERM  = 9'b001000000,
        ST_NEXT  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                cmd.accept = 1'b1;
                if (status.last_beat) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.total_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.log_start = 1'b1;
                    state_next    = ST_LOGN;
                end
            end
            ST_LOGN: begin
                if (status.log_done) begin
                    cmd.save_ln = 1'b1;
                    state_next  = ST_RDBIN;
                end
            end
            ST_RDBIN: begin
                cmd.rd_bin = 1'b1;
                state_next = ST_BIN;
            end
            ST_BIN: begin
                cmd.load_c = 1'b1;
                if (status.bin_zero) begin
                    state_next = ST_NEXT;
                end else begin
                    cmd.log_start   = 1'b1;
                    cmd.log_src_bin = 1'b1;
                    state_next      = ST_LOGC;
                end
            end
            ST_LOGC: begin
                if (status.log_done) begin
                    cmd.term_start = 1'b1;
                    state_next     = ST_TERM;
                end
            end
            ST_TERM: begin
                if (status.term_done) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cmd.idx_inc = 1'b1;
                state_next  = status.idx_last ? ST_OUT : ST_RDBIN;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.blk_clear = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/byte_shannon_entropy_top.sv =====
// Top level of the byte Shannon entropy block.
//
//  Channel  Direction  Beat contents
//  s_       in         tdata: data_byte[7:0]; tuser: byte_valid; tlast: block_last
//  m_       out        tdata: entropy_q16[19:0], total_bytes[51:20], zero fill to 56 bits
//
// Bytes are taken one beat per cycle into the histogram until a beat with tlast.
// That beat starts the bin walk: log2 of the total, then each of the 256 bins is read in
// turn, and a non-empty bin adds a log2 of its count plus a serial multiply by the LW-bit
// log difference and a serial divide by the total,
// where LW = clog2(COUNT_BITS) + FRAC_BITS + 8.
// Reset clears the per-bin valid bits at once; no clearing pass is needed.
// A result waiting on m_tready does not stop the next block from streaming in.
module byte_shannon_entropy_top #(
    parameter int COUNT_BITS = bse_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bse_pkg::S_DATA_W-1:0]  s_tdata,   // data_byte
    input  logic                          s_tuser,   // byte_valid
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bse_pkg::M_DATA_W-1:0]  m_tdata    // entropy_q16, total_bytes
);
    import bse_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign s_tready = cmd.accept;

    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    bse_dp #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the byte Shannon entropy block.
`timescale 1ns / 100ps

class entropy_scoreboard;
    logic [31:0] bin_count [256];
    logic [31:0] byte_count;
    logic [19:0] entropy_queue [$];
    logic [31:0] total_queue [$];
    int mismatches;
    int results_seen;

    function new();
        reset_histogram();
        mismatches = 0;
        results_seen = 0;
    endfunction

    function void reset_histogram();
        foreach (bin_count[i]) bin_count[i] = '0;
        byte_count = '0;
    endfunction

    function logic [63:0] log2_fixed(logic [63:0] x);
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        int k;
        t = x;
        k = 0;
        frac = 0;
        if (x == 0) return 0;
        while (t > 1) begin
            t = t >> 1;
            k++;
        end
        if (k > 30) m = x >> (k - 30);
        else m = x << (30 - k);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (64'(k) << 24) | frac;
    endfunction

    function logic [19:0] block_entropy();
        logic [63:0] ln;
        logic [63:0] lc;
        logic [63:0] sum;
        logic [127:0] prod;
        logic [63:0] res;
        sum = 0;
        if (byte_count == 0) return 0;
        ln = log2_fixed(64'(byte_count));
        for (int i = 0; i < 256; i++) begin
            if (bin_count[i] != 0) begin
                lc = log2_fixed(64'(bin_count[i]));
                if (lc < ln) begin
                    prod = 128'(bin_count[i]) * 128'(ln - lc);
                    sum = sum + 64'(prod / 128'(byte_count));
                end
            end
        end
        res = (sum + 64'd128) >> 8;
        if (res > (64'd8 << 16)) res = 64'd8 << 16;
        return res[19:0];
    endfunction

    function void note_byte(logic [7:0] data, logic valid, logic last);
        if (valid) begin
            if (bin_count[data] != 32'hFFFF_FFFF) bin_count[data]++;
            if (byte_count != 32'hFFFF_FFFF) byte_count++;
        end
        if (last) begin
            entropy_queue.push_back(block_entropy());
            total_queue.push_back(byte_count);
            reset_histogram();
        end
    endfunction

    function void check_result(logic [55:0] tdata);
        logic [19:0] exp_entropy;
        logic [31:0] exp_total;
        results_seen++;
        if (entropy_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: %h", tdata);
            return;
        end
        exp_entropy = entropy_queue.pop_front();
        exp_total = total_queue.pop_front();
        if (tdata[19:0] !== exp_entropy || tdata[51:20] !== exp_total
                || tdata[55:52] !== 4'h0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: entropy exp %0d got %0d, total exp %0d got %0d",
                         exp_entropy, tdata[19:0], exp_total, tdata[51:20]);
        end
    endfunction
endclass

module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    entropy_scoreboard histo_board = new();
    int  cycle_count = 0;
    int  beats_sent = 0;
    int  blocks_sent = 0;
    int  src_gap_max = 18;
    int  sink_gap_max = 18;

    byte_shannon_entropy_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("** byte_shannon_entropy_top: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) histo_board.check_result(m_tdata);
    end

    initial begin : sink_side
        int gap;
        forever begin
            @(negedge aclk);
            if (sink_gap_max == 0) gap = 0;
            else gap = $urandom_range(0, sink_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic valid, input logic last);
        int gap;
        if (src_gap_max == 0) gap = 0;
        else gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= valid;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        histo_board.note_byte(data, valid, last);
        beats_sent++;
        if (last) blocks_sent++;
        @(negedge aclk);
    endtask

    task automatic send_block(input int length, input int mode);
        logic [7:0] b;
        for (int i = 0; i < length; i++) begin
            case (mode)
                0: b = 8'($urandom);
                1: b = 8'($urandom_range(0, 3));
                default: b = 8'hA5;
            endcase
            send_beat(b, ($urandom_range(0, 9) != 0), (i == length - 1));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty block, invalid-only block, single bytes at both extremes.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h12, 1'b0, 1'b0);
        send_beat(8'h34, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        // Two distinct bytes, one repeated byte, then alternating bit patterns.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b1);
        send_beat(8'hAA, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h0F, 1'b1, 1'b0);
        send_beat(8'hF0, 1'b1, 1'b0);
        send_beat(8'h77, 1'b0, 1'b1);

        // Random blocks; some phases run without any idling.
        while (beats_sent < 275) begin
            if ($urandom_range(0, 5) == 0) begin
                src_gap_max = 0;
                sink_gap_max = 0;
            end else begin
                src_gap_max = 18;
                sink_gap_max = 18;
            end
            send_block($urandom_range(1, 24), $urandom_range(0, 2));
        end
        // One block covering all 256 byte values for full entropy.
        src_gap_max = 0;
        for (int i = 0; i < 256; i++) send_beat(8'(i), 1'b1, (i == 255));
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (histo_board.entropy_queue.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d beats in %0d blocks; checked %0d entropy results.",
                 beats_sent, blocks_sent, histo_board.results_seen);
        $display("Mismatches counted: %0d.", histo_board.mismatches);
        if (histo_board.mismatches == 0) begin
            $display("** byte_shannon_entropy_top: PASSED **");
        end else begin
            $display("** byte_shannon_entropy_top: FAILED **");
        end
        $finish;
    end
endmodule
